[design/ftl_pkg.sv]
// shared types and constants for the forwarding table lookup block
`timescale 1ns / 1ps

package ftl_pkg;

    localparam int ADDR_W   = 16;
    localparam int NB_W     = 8;
    localparam int STATUS_W = 2;
    localparam int CNT_OUT_W = 4;

    localparam logic REQ_MAP    = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

    typedef struct packed {
        logic              req_type;
        logic [ADDR_W-1:0] address;
        logic [NB_W-1:0]   neighbor;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [NB_W-1:0]      next_hop;
        logic                 hit;
        logic [CNT_OUT_W-1:0] entry_count;
    } rsp_t;

endpackage

[design/ftl_in_reg.sv]
// input register stage holding one request beat
`timescale 1ns / 1ps

module ftl_in_reg
    import ftl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  req_t in_req,
    input  logic advance,
    output logic fire,
    output req_t req
);

    logic valid_reg;
    logic valid_next;
    req_t req_reg;

    assign in_ready = !valid_reg || advance;
    assign fire     = valid_reg && advance;
    assign req      = req_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg <= in_req;
        end
    end

endmodule

[design/ftl_table.sv]
// table storage, parallel compares, map update and lookup pick
`timescale 1ns / 1ps

module ftl_table
    import ftl_pkg::*;
#(
    parameter int TABLE_ENTRIES = 8
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_wr_en,
    input  logic [NB_W-1:0] cfg_wr_data,
    input  logic            fire,
    input  req_t            req,
    output rsp_t            rsp
);

    localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int COUNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int EXT_W   = COUNT_W + CNT_OUT_W;

    logic [ADDR_W-1:0]  addr_reg [TABLE_ENTRIES];
    logic [NB_W-1:0]    nb_reg   [TABLE_ENTRIES];
    logic [COUNT_W-1:0] fill_reg;
    logic [COUNT_W-1:0] fill_next;
    logic [NB_W-1:0]    default_nb_reg;

    logic             nb_found;
    logic [IDX_W-1:0] nb_idx;
    logic             addr_found;
    logic [NB_W-1:0]  addr_nb;
    logic             is_full;
    logic             wr_en;
    logic             wr_new;
    logic [IDX_W-1:0] wr_idx;
    logic [EXT_W-1:0] count_ext;

    // lowest occupied entry holding the neighbor, highest occupied entry matching the address
    always_comb
    begin
        nb_found   = 1'b0;
        nb_idx     = '0;
        addr_found = 1'b0;
        addr_nb    = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if ((COUNT_W'(i) < fill_reg) && (nb_reg[i] == req.neighbor))
            begin
                nb_found = 1'b1;
                nb_idx   = IDX_W'(i);
            end
        end
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if ((COUNT_W'(i) < fill_reg) && (addr_reg[i] == req.address))
            begin
                addr_found = 1'b1;
                addr_nb    = nb_reg[i];
            end
        end
    end

    assign is_full = (fill_reg >= COUNT_W'(TABLE_ENTRIES));

    always_comb
    begin
        wr_en        = 1'b0;
        wr_new       = 1'b0;
        wr_idx       = nb_idx;
        fill_next    = fill_reg;
        rsp.status   = ST_OK;
        rsp.next_hop = '0;
        rsp.hit      = 1'b0;
        if (req.req_type == REQ_MAP)
        begin
            if ((req.address == '0) || (req.neighbor == '0))
            begin
                rsp.status = ST_INVALID;
            end
            else if (nb_found)
            begin
                wr_en = 1'b1;
            end
            else if (is_full)
            begin
                rsp.status = ST_FULL;
            end
            else
            begin
                wr_en     = 1'b1;
                wr_new    = 1'b1;
                wr_idx    = fill_reg[IDX_W-1:0];
                fill_next = fill_reg + COUNT_W'(1);
            end
        end
        else
        begin
            rsp.hit      = addr_found;
            rsp.next_hop = addr_found ? addr_nb : default_nb_reg;
        end
        count_ext       = EXT_W'(fill_next);
        rsp.entry_count = count_ext[CNT_OUT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg       <= '0;
            default_nb_reg <= '0;
        end
        else
        begin
            if (fire)
            begin
                fill_reg <= fill_next;
            end
            if (cfg_wr_en)
            begin
                default_nb_reg <= cfg_wr_data;
            end
        end
    end

    // entries at or above the fill count are never read, so storage needs no reset
    always_ff @(posedge clk)
    begin
        if (fire && wr_en)
        begin
            addr_reg[wr_idx] <= req.address;
            if (wr_new)
            begin
                nb_reg[wr_idx] <= req.neighbor;
            end
        end
    end

endmodule

[design/ftl_out_reg.sv]
// result register toward the master side
`timescale 1ns / 1ps

module ftl_out_reg
    import ftl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic fire,
    input  rsp_t rsp_in,
    output logic advance,
    output logic out_valid,
    input  logic out_ready,
    output rsp_t rsp
);

    logic valid_reg;
    logic valid_next;
    rsp_t rsp_reg;

    assign advance   = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (fire)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rsp_reg <= rsp_in;
        end
    end

endmodule

[design/forwarding_table_lookup_top.sv]
// top level of the forwarding table lookup block
`timescale 1ns / 1ps

// forwarding table with a default route
// - slave stream carries requests: map an address to a neighbor, or look up an address
// - master stream carries one result beat per request: status, next hop, hit, entry count
// - cfg_wr_en/cfg_wr_data set the default neighbor returned on a lookup miss (0 = none);
//   write it only while no request is in flight
// - a request beat goes into an input register; from there the whole table is
//   compared in parallel, updated on a map, and the result lands in the output register
// - the input register and then the output register lie between the accepting edge and m_tvalid
// - throughput: one beat per cycle while m_tready stays high; set by the single table
//   compare/update pass, which reads the table left by the previous beat
// - stall: when m_tready is low the result holds, the input register keeps one more
//   beat and s_tready drops only once both stages are full
// - reset: table empty, entry count 0, default neighbor 0, both streams idle

module forwarding_table_lookup_top
    import ftl_pkg::*;
#(
    parameter int TABLE_ENTRIES = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    // default neighbor write
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // address[15:0], neighbor[23:16]
    input  logic [0:0]  s_tuser,   // req_type[0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // status[1:0], next_hop[9:2], hit[10], entry_count[14:11], zero
);

    req_t in_req;
    req_t req;
    rsp_t rsp_comb;
    rsp_t rsp;
    logic fire;
    logic advance;

    assign in_req.req_type = s_tuser[0];
    assign in_req.address  = s_tdata[15:0];
    assign in_req.neighbor = s_tdata[23:16];

    ftl_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_req   (in_req),
        .advance  (advance),
        .fire     (fire),
        .req      (req)
    );

    ftl_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fire        (fire),
        .req         (req),
        .rsp         (rsp_comb)
    );

    ftl_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .rsp_in    (rsp_comb),
        .advance   (advance),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .rsp       (rsp)
    );

    // result fields packed from bit 0 upward, top bit padded
    assign m_tdata = {1'b0, rsp.entry_count, rsp.hit, rsp.next_hop, rsp.status};

endmodule

[verif/forwarding_table_lookup_top_tb.sv]
// self-checking testbench for the forwarding table lookup top level
`timescale 1ns / 1ps

module forwarding_table_lookup_top_tb;
    import ftl_pkg::*;

    localparam int TABLE_DEPTH = 8;
    localparam int POOL_SIZE   = 12;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [7:0]  cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // address[15:0], neighbor[23:16]
    logic [0:0]  s_tuser;   // req_type[0]
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // status[1:0], next_hop[9:2], hit[10], entry_count[14:11], zero

    // high while both sides run without random idle cycles
    bit steady;

    logic [15:0] addr_pool [POOL_SIZE];

    // shadow forwarding table plus the queue of result beats still owed by the block
    class hop_tracker;
        logic [ADDR_W-1:0] addr_tab [];
        logic [NB_W-1:0]   nb_tab [];
        int                depth;
        int                fill;
        logic [NB_W-1:0]   dflt;
        rsp_t              hops_due [$];
        int                errors;
        int                maps;
        int                lookups;
        int                hits;
        int                fulls;
        int                invalids;

        function new(int entries);
            depth    = entries;
            addr_tab = new[entries];
            nb_tab   = new[entries];
            foreach (addr_tab[i])
            begin
                addr_tab[i] = '0;
                nb_tab[i]   = '0;
            end
            fill     = 0;
            dflt     = '0;
            errors   = 0;
            maps     = 0;
            lookups  = 0;
            hits     = 0;
            fulls    = 0;
            invalids = 0;
        endfunction

        function void set_default(logic [NB_W-1:0] v);
            dflt = v;
        endfunction

        function int outstanding();
            return hops_due.size();
        endfunction

        // apply one accepted request to the shadow table and queue its result
        function void note_request(req_t r);
            rsp_t e;
            int   slot;
            e    = '0;
            slot = -1;
            if (r.req_type == REQ_MAP)
            begin
                maps++;
                if (r.address == '0 || r.neighbor == '0)
                begin
                    e.status = ST_INVALID;
                    invalids++;
                end
                else
                begin
                    // lowest entry already holding this neighbor gets the new address
                    for (int i = 0; i < fill; i++)
                        if (slot < 0 && nb_tab[i] == r.neighbor)
                            slot = i;
                    if (slot >= 0)
                    begin
                        addr_tab[slot] = r.address;
                        e.status = ST_OK;
                    end
                    else if (fill >= depth)
                    begin
                        e.status = ST_FULL;
                        fulls++;
                    end
                    else
                    begin
                        addr_tab[fill] = r.address;
                        nb_tab[fill]   = r.neighbor;
                        fill++;
                        e.status = ST_OK;
                    end
                end
            end
            else
            begin
                lookups++;
                e.status   = ST_OK;
                e.next_hop = dflt;
                // highest matching occupied entry wins
                for (int i = 0; i < fill; i++)
                    if (addr_tab[i] == r.address)
                    begin
                        e.next_hop = nb_tab[i];
                        e.hit      = 1'b1;
                    end
                if (e.hit)
                    hits++;
            end
            e.entry_count = CNT_OUT_W'(fill);
            hops_due.push_back(e);
        endfunction

        function void check_result(logic [15:0] beat);
            rsp_t e;
            if (hops_due.size() == 0)
            begin
                errors++;
                $display("%0t: result beat %h arrived with nothing outstanding", $time, beat);
                return;
            end
            e = hops_due.pop_front();
            if (beat[1:0] !== e.status)
            begin
                errors++;
                $display("%0t: status expected %0d actual %0d", $time, e.status, beat[1:0]);
            end
            if (beat[9:2] !== e.next_hop)
            begin
                errors++;
                $display("%0t: next_hop expected %h actual %h", $time, e.next_hop, beat[9:2]);
            end
            if (beat[10] !== e.hit)
            begin
                errors++;
                $display("%0t: hit expected %b actual %b", $time, e.hit, beat[10]);
            end
            if (beat[14:11] !== e.entry_count)
            begin
                errors++;
                $display("%0t: entry_count expected %0d actual %0d", $time, e.entry_count,
                         beat[14:11]);
            end
            if (beat[15] !== 1'b0)
            begin
                errors++;
                $display("%0t: pad bit expected 0 actual %b", $time, beat[15]);
            end
        endfunction
    endclass

    hop_tracker book;

    forwarding_table_lookup_top #(
        .TABLE_ENTRIES (TABLE_DEPTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #5 clk = ~clk;

    // result side: check every accepted beat, then pick the next ready value
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                book.check_result(m_tdata);
            m_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 29);
        end
    end

    // present one request beat and hold it until the block takes it
    task automatic send_req(input logic kind, input logic [15:0] addr, input logic [7:0] nb);
        req_t r;
        r.req_type = kind;
        r.address  = addr;
        r.neighbor = nb;
        s_tvalid <= 1'b1;
        s_tdata  <= {nb, addr};
        s_tuser  <= kind;
        do
            @(posedge clk);
        while (!s_tready);
        book.note_request(r);
        if (!steady && $urandom_range(0, 99) < 29)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
    endtask

    // stop sending and wait until every owed result beat has come back
    task automatic settle();
        s_tvalid <= 1'b0;
        while (book.outstanding() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // only called once the block is idle
    task automatic set_default(input logic [7:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        book.set_default(v);
        cfg_wr_en <= 1'b0;
    endtask

    // mostly well-formed maps and lookups aimed at stored entries, with some noise
    task automatic run_phase(input int n);
        int          roll;
        logic [15:0] addr;
        logic [7:0]  nb;
        for (int k = 0; k < n; k++)
        begin
            // sender holds off once per phase until the pipe is empty
            if (k == n / 2)
                settle();
            roll = $urandom_range(0, 99);
            if (roll < 8)
            begin
                // broken mapping: zero address or zero neighbor
                if ($urandom_range(0, 1))
                    send_req(REQ_MAP, 16'h0000, 8'($urandom_range(0, 255)));
                else
                    send_req(REQ_MAP, 16'($urandom_range(0, 65535)), 8'h00);
            end
            else if (roll < 14)
            begin
                send_req(REQ_LOOKUP, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
            end
            else if (roll < 55)
            begin
                if ($urandom_range(0, 99) < 20)
                    addr = 16'($urandom_range(1, 65535));
                else
                    addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
                // reuse a stored neighbor most of the time so entries get rewritten
                nb = book.nb_tab[$urandom_range(0, TABLE_DEPTH - 1)];
                if (nb == 8'h00 || $urandom_range(0, 99) < 35)
                    nb = 8'($urandom_range(1, 255));
                send_req(REQ_MAP, addr, nb);
            end
            else
            begin
                if ($urandom_range(0, 99) < 70)
                    addr = book.addr_tab[$urandom_range(0, TABLE_DEPTH - 1)];
                else
                    addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
                send_req(REQ_LOOKUP, addr, 8'($urandom_range(0, 255)));
            end
        end
        settle();
    endtask

    // hard stop in case the block hangs
    initial
    begin
        #2_000_000;
        $display("forwarding_table_lookup_top_tb NOT OK");
        $finish;
    end

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 8'h00;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        steady      = 1'b0;
        book        = new(TABLE_DEPTH);
        addr_pool[0] = 16'hFFFF;
        addr_pool[1] = 16'h0001;
        for (int i = 2; i < POOL_SIZE; i++)
            addr_pool[i] = 16'($urandom_range(1, 65535));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, invalid mappings, replace at entry 0,
        // duplicate addresses, filling to full and replacing while full
        send_req(REQ_LOOKUP, 16'h0000, 8'h00);
        send_req(REQ_LOOKUP, 16'h1234, 8'hFF);
        send_req(REQ_MAP, 16'h0000, 8'h05);
        send_req(REQ_MAP, 16'h1234, 8'h00);
        send_req(REQ_MAP, 16'h0000, 8'h00);
        send_req(REQ_MAP, 16'hFFFF, 8'hFF);
        send_req(REQ_LOOKUP, 16'hFFFF, 8'h00);
        send_req(REQ_MAP, 16'h0001, 8'h01);
        send_req(REQ_MAP, 16'h1234, 8'hFF);
        send_req(REQ_LOOKUP, 16'hFFFF, 8'hAA);
        send_req(REQ_LOOKUP, 16'h1234, 8'h55);
        send_req(REQ_MAP, 16'h1234, 8'h03);
        send_req(REQ_LOOKUP, 16'h1234, 8'h00);
        send_req(REQ_MAP, 16'h00AA, 8'h04);
        send_req(REQ_MAP, 16'h5555, 8'h05);
        send_req(REQ_MAP, 16'hAAAA, 8'h06);
        send_req(REQ_MAP, 16'h8000, 8'h07);
        send_req(REQ_MAP, 16'h7FFF, 8'h08);
        send_req(REQ_MAP, 16'h0F0F, 8'h09);
        send_req(REQ_MAP, 16'h0F0F, 8'h01);
        send_req(REQ_LOOKUP, 16'h0F0F, 8'h00);
        send_req(REQ_MAP, 16'h0000, 8'h09);
        send_req(REQ_LOOKUP, 16'h0000, 8'hFF);
        settle();

        // misses now return the all-ones default
        set_default(8'hFF);
        send_req(REQ_LOOKUP, 16'h0000, 8'h00);
        send_req(REQ_LOOKUP, 16'h0001, 8'h00);
        run_phase(400);

        // no default route, both sides streaming flat out
        set_default(8'h00);
        steady = 1'b1;
        run_phase(300);
        steady = 1'b0;

        set_default(8'($urandom_range(1, 254)));
        run_phase(500);

        set_default(8'h80);
        run_phase(600);

        settle();
        repeat (8) @(posedge clk);
        if (book.outstanding() != 0)
        begin
            book.errors++;
            $display("%0t: %0d result beats never arrived", $time, book.outstanding());
        end

        $display("ran %0d maps (%0d rejected as full, %0d invalid) and %0d lookups (%0d hits)",
                 book.maps, book.fulls, book.invalids, book.lookups, book.hits);
        $display("under four default-neighbor settings with random stalls on both streams");
        if (book.errors == 0)
            $display("forwarding_table_lookup_top_tb OK");
        else
            $display("forwarding_table_lookup_top_tb NOT OK");
        $finish;
    end

endmodule

[files.f]
design/ftl_pkg.sv
design/ftl_in_reg.sv
design/ftl_table.sv
design/ftl_out_reg.sv
design/forwarding_table_lookup_top.sv
verif/forwarding_table_lookup_top_tb.sv
